### sv/vvjsl_pkg.sv
// Shared types and constants of the vertical velocity jerk slew limiter.
package vvjsl_pkg;

  localparam int unsigned IN_W   = 80;
  localparam int unsigned OUT_W  = 24;
  localparam int unsigned CFG_W  = 26;

  localparam logic [22:0] ACCEL_UP_RESET   = 23'd196608;
  localparam logic [22:0] ACCEL_DOWN_RESET = 23'd65536;
  localparam logic [25:0] JERK_RESET       = 26'd65536;
  localparam logic signed [23:0] VEL_LIMIT = 24'sd6553600;

  typedef logic [1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    CFG_ACCEL_UP_MAX   = 2'd0,
    CFG_ACCEL_DOWN_MAX = 2'd1,
    CFG_JERK_LIMIT     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic mul_a;
    logic upd_lim;
    logic mul_b;
    logic slew;
  } cmd_t;

endpackage

### sv/vvjsl_ctrl.sv
// Sequencing state machine of the vertical velocity jerk slew limiter.
module vvjsl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output vvjsl_pkg::cmd_t    cmd
);
  import vvjsl_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    MUL_A,
    LIMIT,
    MUL_B,
    SLEW
  } state_t;

  state_t state;

  assign s_tready = (state == IDLE) && !rst;

  always_comb begin
    cmd         = '0;
    cmd.load    = s_tvalid && s_tready;
    cmd.mul_a   = (state == MUL_A);
    cmd.upd_lim = (state == LIMIT);
    cmd.mul_b   = (state == MUL_B);
    cmd.slew    = (state == SLEW) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE:    if (cmd.load) state <= MUL_A;
        MUL_A:   state <= LIMIT;
        LIMIT:   state <= MUL_B;
        MUL_B:   state <= SLEW;
        SLEW:    if (cmd.slew) state <= IDLE;
        default: state <= IDLE;
      endcase
      if (cmd.slew) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### sv/vvjsl_dp.sv
// Datapath of the vertical velocity jerk slew limiter with one shared multiplier.
module vvjsl_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  vvjsl_pkg::cmd_t             cmd,
  input  logic [vvjsl_pkg::IN_W-1:0]  in_data,
  output logic [vvjsl_pkg::OUT_W-1:0] out_data,
  input  logic                        cfg_we,
  input  vvjsl_pkg::cfg_idx_t         cfg_addr,
  input  logic [vvjsl_pkg::CFG_W-1:0] cfg_data
);
  import vvjsl_pkg::*;

  localparam logic signed [26:0] VMAX = 27'(VEL_LIMIT);
  localparam logic signed [26:0] VMIN = -VMAX;

  logic [22:0]        up;
  logic [22:0]        down;
  logic [25:0]        jerk;
  logic signed [23:0] req;
  logic signed [15:0] stick;
  logic signed [23:0] meas;
  logic [15:0]        dt;
  logic signed [23:0] prev;
  logic [24:0]        limit;
  logic               brk;
  logic [41:0]        prod;
  logic signed [23:0] vout;

  logic               braking;
  logic               neg;
  logic [15:0]        mag;
  logic               up_lt_down;
  logic [22:0]        absdiff;
  logic [25:0]        op_a;
  logic [15:0]        op_b;
  logic [41:0]        mul_out;
  logic signed [26:0] gap;
  logic               gap_pos;
  logic [41:0]        gap_sh;
  logic [26:0]        ramp;
  logic [27:0]        q;
  logic signed [29:0] interp;
  logic [24:0]        limit_next;
  logic signed [24:0] d;
  logic [24:0]        ad;
  logic [41:0]        ad_sh;
  logic [24:0]        step;
  logic signed [26:0] pv;
  logic signed [26:0] v_raw;
  logic signed [23:0] v_sat;

  assign braking    = (stick == 16'sd0);
  assign neg        = stick[15];
  assign mag        = neg ? 16'(-stick) : 16'(stick);
  assign up_lt_down = (up < down);
  assign absdiff    = up_lt_down ? (down - up) : (up - down);

  always_comb begin
    if (cmd.mul_b) begin
      op_a = {1'b0, limit};
      op_b = dt;
    end else if (braking) begin
      op_a = jerk;
      op_b = dt;
    end else begin
      op_a = neg ? {3'b000, absdiff} : 26'd0;
      op_b = mag;
    end
  end

  assign mul_out = 42'(op_a) * 42'(op_b);

  assign gap     = $signed({4'b0000, up}) - $signed({2'b00, limit});
  assign gap_pos = !gap[26] && (gap != 27'sd0);
  assign gap_sh  = {gap[25:0], 16'h0000};
  assign ramp    = {2'b00, limit} + {1'b0, prod[41:16]};
  assign q       = prod[41:14];

  always_comb begin
    if (neg && up_lt_down) begin
      interp = $signed({7'd0, down}) - $signed({2'b00, q});
    end else begin
      interp = $signed({7'd0, down}) + $signed({2'b00, q});
    end
    if (braking) begin
      limit_next = (gap_pos && (gap_sh > prod)) ? ramp[24:0] : {2'b00, up};
    end else begin
      limit_next = interp[29] ? 25'd0 : interp[24:0];
    end
  end

  assign d     = $signed({req[23], req}) - $signed({prev[23], prev});
  assign ad    = d[24] ? 25'(-d) : 25'(d);
  assign ad_sh = {1'b0, ad, 16'h0000};
  assign step  = prod[40:16];

  always_comb begin
    if (d[24]) begin
      pv = 27'(prev) - $signed({2'b00, step});
    end else begin
      pv = 27'(prev) + $signed({2'b00, step});
    end
    v_raw = ((dt != 16'd0) && (ad_sh > prod)) ? pv : 27'(req);
    if (v_raw > VMAX) begin
      v_sat = VEL_LIMIT;
    end else if (v_raw < VMIN) begin
      v_sat = -VEL_LIMIT;
    end else begin
      v_sat = v_raw[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up    <= ACCEL_UP_RESET;
      down  <= ACCEL_DOWN_RESET;
      jerk  <= JERK_RESET;
      prev  <= 24'sd0;
      limit <= {2'b00, ACCEL_UP_RESET};
      brk   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ACCEL_UP_MAX:   up   <= cfg_data[22:0];
          CFG_ACCEL_DOWN_MAX: down <= cfg_data[22:0];
          CFG_JERK_LIMIT:     jerk <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.mul_a && braking && !brk) begin
        limit <= {2'b00, down};
        prev  <= meas;
      end
      if (cmd.upd_lim) begin
        limit <= limit_next;
        brk   <= braking;
      end
      if (cmd.slew) begin
        prev <= v_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= in_data[23:0];
      stick <= in_data[39:24];
      meas  <= in_data[63:40];
      dt    <= in_data[79:64];
    end
    if (cmd.mul_a || cmd.mul_b) begin
      prod <= mul_out;
    end
    if (cmd.slew) begin
      vout <= v_sat;
    end
  end

  assign out_data = vout;

endmodule

### sv/vertical_velocity_jerk_slew_limiter.sv
// Top level of the vertical velocity jerk slew limiter.
//
// One input beat per control tick on the s_ side carries the requested velocity,
// the stick deflection, the measured velocity and the time step. One output beat
// on the m_ side carries the limited velocity setpoint for that tick.
// After a beat is accepted the block works on it in order: one product on the
// shared multiplier, the limit update, a second product on the same multiplier and
// the slew and saturation step, which registers the result. A new beat is taken
// only once the block is back in idle, so beats are never overlapped.
// The two chained multiplications share the single multiplier.
// The output register holds a result until it is taken. While it is full and the
// receiver stalls, the block finishes the next tick up to the slew step and waits.
// The configuration port writes one register per cycle at cfg_addr when cfg_we is
// high. The user must use it only while the block is idle; it is not enforced.
// Synchronous reset restores the register defaults, clears the previous setpoint and
// the brake flag, sets the limit to the up maximum and empties the output register.
module vertical_velocity_jerk_slew_limiter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // velocity_request[23:0], stick_position[39:24], measured_velocity[63:40],
  // time_step[79:64]
  input  logic [vvjsl_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // velocity_limited[23:0]
  output logic [vvjsl_pkg::OUT_W-1:0] m_tdata,
  input  logic                        cfg_we,
  input  vvjsl_pkg::cfg_idx_t         cfg_addr,
  input  logic [vvjsl_pkg::CFG_W-1:0] cfg_data
);
  import vvjsl_pkg::*;

  cmd_t cmd;

  vvjsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  vvjsl_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .out_data (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

endmodule

### sv/vvjsl_checker.sv
// Port-level assertions of the vertical velocity jerk slew limiter and their bind.
module vvjsl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [vvjsl_pkg::OUT_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("input taken while a tick is in progress");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a tick in progress");

endmodule

bind vertical_velocity_jerk_slew_limiter vvjsl_checker u_vvjsl_checker (.*);

### dv/tb_vertical_velocity_jerk_slew_limiter.sv
// Self-checking testbench for the vertical velocity jerk slew limiter.
module tb_vertical_velocity_jerk_slew_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  import vvjsl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BEATS    = 250;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [15:0] dt;
    logic [23:0] meas;
    logic [15:0] stick;
    logic [23:0] req;
  } tick_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_we;
  cfg_idx_t           cfg_addr;
  logic [CFG_W-1:0]   cfg_data;

  longint up_max      = ACCEL_UP_RESET;
  longint down_max    = ACCEL_DOWN_RESET;
  longint jerk_max    = JERK_RESET;
  longint setpoint_q  = 0;
  longint accel_lim   = ACCEL_UP_RESET;
  bit     brake_on    = 1'b0;

  logic [OUT_W-1:0] setpoint_fifo[$];
  int mismatches   = 0;
  int stall_cycles = 0;
  int rx_hold      = 0;
  int brake_run    = 0;
  bit tx_gaps      = 1'b1;
  bit rx_gaps      = 1'b1;

  vertical_velocity_jerk_slew_limiter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advances the limiter state by one tick and returns the setpoint it produces.
  function automatic logic [OUT_W-1:0] next_setpoint(input tick_t t);
    longint req, stick, meas, dt, jstep, gap, sel, mag, diff, lim, v, d, ad, reach;
    bit centered;
    req   = $signed(t.req);
    stick = $signed(t.stick);
    meas  = $signed(t.meas);
    dt    = t.dt;
    centered = (stick == 0);
    if (centered && !brake_on) begin
      accel_lim  = down_max;
      setpoint_q = meas;
    end
    if (centered) begin
      jstep = jerk_max * dt;
      gap   = up_max - accel_lim;
      if (gap > 0 && (gap <<< 16) > jstep) begin
        accel_lim += jstep >>> 16;
      end else begin
        accel_lim = up_max;
      end
    end else begin
      sel  = (stick < 0) ? up_max : down_max;
      mag  = (stick < 0) ? -stick : stick;
      diff = sel - down_max;
      if (diff < 0) begin
        lim = down_max - (((-diff) * mag) >>> 14);
      end else begin
        lim = down_max + ((diff * mag) >>> 14);
      end
      accel_lim = (lim < 0) ? 0 : lim;
    end
    brake_on = centered;
    v = req;
    if (dt > 0) begin
      d     = req - setpoint_q;
      ad    = (d < 0) ? -d : d;
      reach = accel_lim * dt;
      if ((ad <<< 16) > reach) begin
        v = (d < 0) ? setpoint_q - (reach >>> 16) : setpoint_q + (reach >>> 16);
      end
    end
    if (v > longint'(VEL_LIMIT)) v = VEL_LIMIT;
    if (v < -longint'(VEL_LIMIT)) v = -longint'(VEL_LIMIT);
    setpoint_q = v;
    return v[OUT_W-1:0];
  endfunction

  function automatic tick_t tick_beat(input int req, input int stick, input int meas,
                                      input int dt);
    tick_t t;
    t.req   = req[23:0];
    t.stick = stick[15:0];
    t.meas  = meas[23:0];
    t.dt    = dt[15:0];
    return t;
  endfunction

  // Mostly plausible control ticks with runs of centered stick; some raw noise.
  function automatic tick_t random_tick();
    tick_t  t;
    int     stick;
    int     delta;
    longint near;
    if ($urandom_range(0, 9) == 0) begin
      t.req   = 24'($urandom());
      t.stick = 16'($urandom());
      t.meas  = 24'($urandom());
      t.dt    = 16'($urandom());
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        delta = int'($urandom_range(0, 40000)) - 20000;
        near  = setpoint_q + delta;
        t.req = near[23:0];
      end else begin
        t.req = 24'($urandom_range(0, 13107200) - 6553600);
      end
      t.meas = 24'($urandom_range(0, 13107200) - 6553600);
      if (brake_run > 0) begin
        brake_run--;
        stick = 0;
      end else if ($urandom_range(0, 4) == 0) begin
        brake_run = $urandom_range(1, 10);
        stick = 0;
      end else begin
        stick = int'($urandom_range(0, 32768)) - 16384;
      end
      t.stick = stick[15:0];
      case ($urandom_range(0, 9))
        0:       t.dt = 16'd0;
        1, 2:    t.dt = 16'($urandom());
        default: t.dt = 16'($urandom_range(1, 2000));
      endcase
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do @(posedge clk); while (s_tready !== 1'b1);
    setpoint_fifo.push_back(next_setpoint(t));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (setpoint_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t r, input longint val);
    cfg_we   <= 1'b1;
    cfg_addr <= r;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (r)
      CFG_ACCEL_UP_MAX:   up_max   = val[22:0];
      CFG_ACCEL_DOWN_MAX: down_max = val[22:0];
      CFG_JERK_LIMIT:     jerk_max = val[25:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input longint up, input longint down, input longint jerk);
    wait_idle();
    set_reg(CFG_ACCEL_UP_MAX, up);
    set_reg(CFG_ACCEL_DOWN_MAX, down);
    set_reg(CFG_JERK_LIMIT, jerk);
  endtask

  task automatic flag_mismatch(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, $signed(want),
               $signed(got));
    end
  endtask

  task automatic test_default_settings();
    send_tick(tick_beat(1000000, -16384, 0, 65));
    send_tick(tick_beat(-1000000, 16384, 0, 65));
    send_tick(tick_beat(500000, 0, 200000, 65));
    send_tick(tick_beat(500000, 0, 0, 0));
  endtask

  task automatic test_field_extremes();
    send_tick(tick_beat(6553600, -32768, -6553600, 65535));
    send_tick(tick_beat(-6553600, 32767, 6553600, 65535));
    send_tick(tick_beat(8388607, 0, -8388608, 65535));
    send_tick(tick_beat(-8388608, 0, 8388607, 0));
    send_tick(tick_beat(8388607, 1, 0, 0));
    send_tick(tick_beat(-8388608, -1, 0, 1));
    send_tick(tick_beat(0, 16384, 0, 65535));
    send_tick(tick_beat(0, -16384, 8388607, 1));
  endtask

  task automatic test_register_extremes();
    set_limits(0, 0, 0);
    send_tick(tick_beat(6553600, -16384, 0, 65535));
    send_tick(tick_beat(-6553600, 0, 3000000, 65535));
    set_limits(6553600, 6553600, 65536000);
    send_tick(tick_beat(-6553600, -32768, 0, 65535));
    send_tick(tick_beat(6553600, 0, -6553600, 65535));
    set_limits(0, 6553600, 65536000);
    send_tick(tick_beat(6553600, -32768, 0, 1000));
    send_tick(tick_beat(-6553600, 0, 100000, 1000));
    set_limits(6553600, 0, 1);
    send_tick(tick_beat(6553600, 8192, 0, 655));
    send_tick(tick_beat(6553600, 0, 0, 65535));
  endtask

  task automatic test_brake_ramp();
    set_limits(6553600, 65536, 655360);
    send_tick(tick_beat(2000000, 8000, 0, 6553));
    send_tick(tick_beat(2000000, 0, 100000, 6553));
    send_tick(tick_beat(2000000, 0, 0, 0));
    send_tick(tick_beat(-2000000, 0, 0, 6553));
    send_tick(tick_beat(-2000000, 0, 0, 65535));
  endtask

  task automatic test_output_stall();
    set_limits(ACCEL_UP_RESET, ACCEL_DOWN_RESET, JERK_RESET);
    rx_hold = 100;
    repeat (12) send_tick(random_tick());
    wait_idle();
  endtask

  task automatic test_random_traffic();
    longint up, down, jerk;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          up = ACCEL_UP_RESET; down = ACCEL_DOWN_RESET; jerk = JERK_RESET;
        end
        1: begin
          up = 6553600; down = 6553600; jerk = 65536000;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            up   = $urandom_range(0, 6553600);
            down = $urandom_range(0, 6553600);
            jerk = $urandom_range(0, 65536000);
          end else begin
            up   = $urandom_range(0, 400000);
            down = $urandom_range(0, 400000);
            jerk = $urandom_range(0, 2000000);
          end
        end
      endcase
      set_limits(up, down, jerk);
      tx_gaps = (p < 5);
      rx_gaps = (p < 5);
      repeat (PHASE_BEATS) send_tick(random_tick());
    end
  endtask

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (setpoint_fifo.size() == 0) begin
        flag_mismatch("result beat with nothing pending", 'x, m_tdata);
      end else begin
        want = setpoint_fifo.pop_front();
        if (m_tdata !== want) flag_mismatch("velocity_limited", want, m_tdata);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid === 1'b1 && s_tready === 1'b1) ||
        (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("vertical_velocity_jerk_slew_limiter verification failed");
      $finish;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    cfg_we   <= 1'b0;
    cfg_addr <= CFG_ACCEL_UP_MAX;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_settings();
    test_field_extremes();
    test_register_extremes();
    test_brake_ramp();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0 && setpoint_fifo.size() == 0) begin
      $display("vertical_velocity_jerk_slew_limiter verification clean");
    end else begin
      $display("vertical_velocity_jerk_slew_limiter verification failed");
    end
    $finish;
  end

endmodule
